@@ src/cism_pkg.sv @@
// Shared types, operation codes and the lowercase helper of the substring matcher.
`timescale 1ns / 1ps

package cism_pkg;

    // Operation codes of an input item.
    localparam logic [1:0] OP_PATTERN = 2'd0;
    localparam logic [1:0] OP_TEXT    = 2'd1;
    localparam logic [1:0] OP_END     = 2'd2;

    // What each cell hands to its right-hand neighbor.
    typedef struct packed {
        logic [7:0] pat;
        logic       pat_vld;
        logic [7:0] txt;
        logic       txt_vld;
    } t_cell_data;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic clear;
        logic pat_shift;
        logic txt_shift;
    } t_cell_ctrl;

    // Maps 'A'..'Z' to 'a'..'z' and leaves every other byte as it is.
    function automatic logic [7:0] f_to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

@@ src/case_insensitive_substring_match.sv @@
// Top level of the streaming case-insensitive substring matcher.
//
//   Channel | Handshake                      | Payload
//   --------+--------------------------------+---------------------------------
//   input   | i_in_valid / o_in_ready        | i_operation, i_character
//   output  | o_out_valid / i_out_ready      | o_found, o_pattern_overflow
//
// A new item is accepted each cycle while the output register is empty or
// being drained in the same cycle.
// The verdict appears in the cycle after the end-of-query item is accepted
// and waits in the output register until it is taken.
// Reset (synchronous, active low) clears all valid bits and sticky flags at
// once; the first item may arrive in the cycle after reset is released.
// A stall on the output side only holds back input while the verdict waits.
`timescale 1ns / 1ps

module case_insensitive_substring_match #(
    parameter int MAX_PATTERN = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_character,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_found,
    output logic       o_pattern_overflow
);
    import cism_pkg::*;

    // The chain holds the pattern reversed and the text window newest first,
    // both entering at cell 0. Cell k thus pairs pattern character L-1-k with
    // the text character k places back, so a match is a plain per-cell
    // compare, gated by the pattern valid bit of that cell.
    t_cell_data             w_chain [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0] w_hit;
    t_cell_ctrl             w_ctrl;

    logic       r_match;
    logic       n_match;
    logic       r_overflow;
    logic       n_overflow;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       r_found;
    logic       n_found;
    logic       r_pat_ovf;
    logic       n_pat_ovf;

    logic       w_accept;
    logic       w_is_pat;
    logic       w_is_txt;
    logic       w_is_end;
    logic       w_full;
    logic       w_window_match;
    logic [7:0] w_lower;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_is_pat   = w_accept && (i_operation == OP_PATTERN);
    assign w_is_txt   = w_accept && (i_operation == OP_TEXT);
    assign w_is_end   = w_accept && (i_operation == OP_END);

    // The pattern store is full once the last cell holds a character.
    assign w_full  = w_chain[MAX_PATTERN].pat_vld;
    assign w_lower = f_to_lower(i_character);

    always_comb begin
        w_chain[0].pat     = w_lower;
        w_chain[0].pat_vld = 1'b1;
        w_chain[0].txt     = w_lower;
        w_chain[0].txt_vld = 1'b1;
    end

    always_comb begin
        w_ctrl.clear     = w_is_end;
        w_ctrl.pat_shift = w_is_pat && !w_full;
        w_ctrl.txt_shift = w_is_txt;
    end

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        cism_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_prev  (w_chain[k]),
            .o_data  (w_chain[k+1]),
            .o_hit   (w_hit[k])
        );
    end

    // An empty pattern never sets the sticky flag; it is reported as found
    // at the end of the query instead.
    assign w_window_match = w_chain[1].pat_vld && (&w_hit);

    always_comb begin
        n_match     = r_match;
        n_overflow  = r_overflow;
        n_out_valid = r_out_valid && !i_out_ready;
        n_found     = r_found;
        n_pat_ovf   = r_pat_ovf;
        if (w_is_txt && w_window_match) begin
            n_match = 1'b1;
        end
        if (w_is_pat && w_full) begin
            n_overflow = 1'b1;
        end
        if (w_is_end) begin
            n_out_valid = 1'b1;
            n_found     = r_match || !w_chain[1].pat_vld;
            n_pat_ovf   = r_overflow;
            n_match     = 1'b0;
            n_overflow  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match     <= 1'b0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_match     <= n_match;
            r_overflow  <= n_overflow;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_found   <= n_found;
        r_pat_ovf <= n_pat_ovf;
    end

    assign o_out_valid        = r_out_valid;
    assign o_found            = r_found;
    assign o_pattern_overflow = r_pat_ovf;

endmodule

@@ src/cism_cell.sv @@
// One cell of the chain: a pattern character, a text character and their compare.
`timescale 1ns / 1ps

module cism_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cism_pkg::t_cell_ctrl  i_ctrl,
    input  cism_pkg::t_cell_data  i_prev,
    output cism_pkg::t_cell_data  o_data,
    output logic                  o_hit
);
    import cism_pkg::*;

    t_cell_data r_data;
    t_cell_data n_data;

    always_comb begin
        n_data = r_data;
        priority if (i_ctrl.clear) begin
            n_data.pat_vld = 1'b0;
            n_data.txt_vld = 1'b0;
        end else if (i_ctrl.pat_shift) begin
            n_data.pat     = i_prev.pat;
            n_data.pat_vld = i_prev.pat_vld;
        end else if (i_ctrl.txt_shift) begin
            n_data.txt     = i_prev.txt;
            n_data.txt_vld = i_prev.txt_vld;
        end
    end

    // Only the valid bits need a reset; the characters behind them are don't-care.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data.pat_vld <= 1'b0;
            r_data.txt_vld <= 1'b0;
        end else begin
            r_data.pat_vld <= n_data.pat_vld;
            r_data.txt_vld <= n_data.txt_vld;
        end
        r_data.pat <= n_data.pat;
        r_data.txt <= n_data.txt;
    end

    assign o_data = r_data;

    // The text character about to shift in is the one the neighbor holds now,
    // so the compare sees the window as it stands after this text item.
    assign o_hit = !r_data.pat_vld || (i_prev.txt_vld && (i_prev.txt == r_data.pat));

endmodule

@@ src/cism_checker.sv @@
// Port-level checks of the substring matcher and their bind to the top level.
`timescale 1ns / 1ps

module cism_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [1:0] i_operation,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_found,
    input logic       o_pattern_overflow
);
    import cism_pkg::*;

    // A verdict that is not taken stays valid.
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("verdict dropped while stalled");

    // A stalled verdict keeps its value.
    a_out_stable : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_found) && $stable(o_pattern_overflow))
        else $error("verdict changed while stalled");

    // An accepted end-of-query item shows its verdict in the next cycle.
    a_end_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_operation == OP_END) |=> o_out_valid)
        else $error("end of query gave no verdict");

    // Pattern and text items never produce a verdict of their own.
    a_no_spurious : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && !(i_in_valid && o_in_ready && (i_operation == OP_END))
        |=> !o_out_valid)
        else $error("verdict without end of query");

    // With the output register empty the block takes input.
    a_ready_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

endmodule

bind case_insensitive_substring_match cism_checker u_cism_checker (.*);
